// File: rtl/core/egsa_pkg.sv
// ----------------------------------------------------------------------------
// egsa_pkg
// Shared types and constants for the edge gradient scatter-add unit.
// ----------------------------------------------------------------------------
package egsa_pkg;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_ROW_WIDTH        = 2'd0;
  localparam logic [1:0] REG_GRADIENT_ROWS    = 2'd1;
  localparam logic [1:0] REG_ACCUMULATOR_ROWS = 2'd2;

  localparam logic [5:0] ROW_WIDTH_RESET        = 6'd32;
  localparam logic [8:0] GRADIENT_ROWS_RESET    = 9'd256;
  localparam logic [8:0] ACCUMULATOR_ROWS_RESET = 9'd256;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_EDGE,
    ST_DRAIN,
    ST_EDGE_END,
    ST_READ,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [5:0] row_width;
    logic [8:0] gradient_rows;
    logic [8:0] accumulator_rows;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic grad_write;
    logic edge_init;
    logic edge_issue;
    logic clear_init;
    logic clear_step;
    logic finish;
    logic fin_status;
    logic fin_sat;
    logic fin_read;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    act_t action;
    logic load_ok;
    logic edge_ok;
    logic read_ok;
    logic width_zero;
    logic last_issue;
    logic clear_last;
  } stat_t;

endpackage

// File: rtl/core/edge_gradient_scatter_add_unit.sv
// ----------------------------------------------------------------------------
// edge_gradient_scatter_add_unit
// Gathers gradient rows and adds them, saturating in Q16.16, into accumulator
// rows; also loads gradient elements, reads and clears accumulators.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its single result
// appears on status, saturated and read_value for exactly one cycle while done
// is high; the receiver cannot stall, so it must take every result in the
// cycle it is shown. A load, an edge with a row width of zero, and any item
// that fails its bounds check are finished from the decode state, and a read
// from the read state that follows it. Any other edge issues W elements, W
// being the row width limited to MAX_WIDTH, one per cycle through the single
// read-add-write path of the accumulator memory, then drains and finishes. A
// clear item zeroes one memory entry per cycle over all MAX_ROWS * MAX_WIDTH
// entries, and the same sweep runs after reset, with busy high throughout.
// Configuration writes are accepted at any time but should only be made while
// the block is idle.
module edge_gradient_scatter_add_unit #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [7:0]                   gradient_row,
  input  logic [7:0]                   accumulator_row,
  input  logic [4:0]                   column,
  input  logic signed [31:0]           load_value,
  output logic                         done,
  output logic                         status,
  output logic                         saturated,
  output logic signed [31:0]           read_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [egsa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import egsa_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  egsa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  egsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  egsa_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .action          (action),
    .gradient_row    (gradient_row),
    .accumulator_row (accumulator_row),
    .column          (column),
    .load_value      (load_value),
    .done            (done),
    .status          (status),
    .saturated       (saturated),
    .read_value      (read_value)
  );

endmodule

// File: rtl/core/egsa_regs.sv
// ----------------------------------------------------------------------------
// egsa_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module egsa_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [egsa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output egsa_pkg::cfg_t              cfg
);
  import egsa_pkg::*;

  logic wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width        <= ROW_WIDTH_RESET;
      cfg.gradient_rows    <= GRADIENT_ROWS_RESET;
      cfg.accumulator_rows <= ACCUMULATOR_ROWS_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_ROW_WIDTH:        cfg.row_width        <= pwdata[5:0];
        REG_GRADIENT_ROWS:    cfg.gradient_rows    <= pwdata[8:0];
        REG_ACCUMULATOR_ROWS: cfg.accumulator_rows <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ROW_WIDTH:        prdata = {26'd0, cfg.row_width};
      REG_GRADIENT_ROWS:    prdata = {23'd0, cfg.gradient_rows};
      REG_ACCUMULATOR_ROWS: prdata = {23'd0, cfg.accumulator_rows};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/egsa_ctrl.sv
// ----------------------------------------------------------------------------
// egsa_ctrl
// Controller state machine: sequences loads, edges, reads and clears.
// ----------------------------------------------------------------------------
module egsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  egsa_pkg::stat_t stat,
  output egsa_pkg::cmd_t  cmd
);
  import egsa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_INIT: begin
        // The accumulator store is swept to zero after reset.
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.action)
          ACT_LOAD: begin
            cmd.grad_write = stat.load_ok;
            cmd.finish     = 1'b1;
            cmd.fin_status = !stat.load_ok;
            state_next     = ST_IDLE;
          end
          ACT_EDGE: begin
            if (!stat.edge_ok || stat.width_zero) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = !stat.edge_ok;
              state_next     = ST_IDLE;
            end else begin
              cmd.edge_init = 1'b1;
              state_next    = ST_EDGE;
            end
          end
          ACT_READ: begin
            if (stat.read_ok) begin
              state_next = ST_READ;
            end else begin
              cmd.finish     = 1'b1;
              cmd.fin_status = 1'b1;
              state_next     = ST_IDLE;
            end
          end
          default: begin
            cmd.clear_init = 1'b1;
            state_next     = ST_CLEAR;
          end
        endcase
      end
      ST_EDGE: begin
        cmd.edge_issue = 1'b1;
        if (stat.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        // The last element is written back in this cycle.
        state_next = ST_EDGE_END;
      end
      ST_EDGE_END: begin
        cmd.finish  = 1'b1;
        cmd.fin_sat = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_READ: begin
        cmd.finish   = 1'b1;
        cmd.fin_read = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// File: rtl/core/egsa_datapath.sv
// ----------------------------------------------------------------------------
// egsa_datapath
// Item registers, gradient and accumulator memories, the saturating
// read-add-write path and the result registers.
// ----------------------------------------------------------------------------
module egsa_datapath #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  egsa_pkg::cfg_t     cfg,
  input  egsa_pkg::cmd_t     cmd,
  output egsa_pkg::stat_t    stat,
  input  logic [1:0]         action,
  input  logic [7:0]         gradient_row,
  input  logic [7:0]         accumulator_row,
  input  logic [4:0]         column,
  input  logic signed [31:0] load_value,
  output logic               done,
  output logic               status,
  output logic               saturated,
  output logic signed [31:0] read_value
);
  import egsa_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [31:0] ROWS_L  = 32'(MAX_ROWS);
  localparam logic [31:0] WIDTH_L = 32'(MAX_WIDTH);
  localparam logic [31:0] DEPTH_L = 32'(DEPTH);

  logic [31:0] gmem [DEPTH];
  logic [31:0] amem [DEPTH];

  act_t        act_q;
  logic [7:0]  grow_q;
  logic [7:0]  arow_q;
  logic [4:0]  col_q;
  logic [31:0] lval_q;

  logic [COL_W-1:0]  k_q;
  logic [ADDR_W-1:0] clr_q;
  logic              pend_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic              sat_q;

  logic [31:0] g_rdata;
  logic [31:0] a_rdata;

  logic              grow_ok, arow_ok, col_ok;
  logic [31:0]       w_eff;
  logic [ADDR_W-1:0] g_ld_addr, g_edge_addr, a_edge_addr, a_col_addr, a_raddr;
  logic [32:0]       sum;
  logic              ovf;
  logic [31:0]       sum_sat;
  logic              a_we;
  logic [ADDR_W-1:0] a_waddr;
  logic [31:0]       a_wdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= act_t'(action);
      grow_q <= gradient_row;
      arow_q <= accumulator_row;
      col_q  <= column;
      lval_q <= load_value;
    end
  end

  // Row counts above the store depth are limited to the store depth.
  assign grow_ok = ({1'b0, grow_q} < cfg.gradient_rows) && (32'(grow_q) < ROWS_L);
  assign arow_ok = ({1'b0, arow_q} < cfg.accumulator_rows) && (32'(arow_q) < ROWS_L);
  assign col_ok  = 32'(col_q) < WIDTH_L;
  assign w_eff   = (32'(cfg.row_width) > WIDTH_L) ? WIDTH_L : 32'(cfg.row_width);

  assign g_ld_addr   = ADDR_W'(32'(grow_q) * WIDTH_L + 32'(col_q));
  assign g_edge_addr = ADDR_W'(32'(grow_q) * WIDTH_L + 32'(k_q));
  assign a_edge_addr = ADDR_W'(32'(arow_q) * WIDTH_L + 32'(k_q));
  assign a_col_addr  = ADDR_W'(32'(arow_q) * WIDTH_L + 32'(col_q));
  assign a_raddr     = cmd.edge_issue ? a_edge_addr : a_col_addr;

  always_comb begin
    stat.action     = act_q;
    stat.load_ok    = grow_ok && col_ok;
    stat.edge_ok    = grow_ok && arow_ok;
    stat.read_ok    = arow_ok && col_ok;
    stat.width_zero = (cfg.row_width == 6'd0);
    stat.last_issue = (32'(k_q) == w_eff - 32'd1);
    stat.clear_last = (32'(clr_q) == DEPTH_L - 32'd1);
  end

  // Element counter and the one-deep read-to-write pipeline of an edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_q    <= '0;
      pend_q <= 1'b0;
      clr_q  <= '0;
    end else begin
      pend_q <= cmd.edge_issue;
      if (cmd.edge_init) begin
        k_q <= '0;
      end else if (cmd.edge_issue) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd.clear_init) begin
        clr_q <= '0;
      end else if (cmd.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_issue) wr_addr_q <= a_edge_addr;
  end

  assign sum     = {a_rdata[31], a_rdata} + {g_rdata[31], g_rdata};
  assign ovf     = sum[32] ^ sum[31];
  assign sum_sat = ovf ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];

  always_ff @(posedge clk) begin
    if (cmd.edge_init) begin
      sat_q <= 1'b0;
    end else if (pend_q && ovf) begin
      sat_q <= 1'b1;
    end
  end

  // Gradient memory
  always_ff @(posedge clk) begin
    if (cmd.grad_write) gmem[g_ld_addr] <= lval_q;
    g_rdata <= gmem[g_edge_addr];
  end

  assign a_we    = cmd.clear_step || pend_q;
  assign a_waddr = cmd.clear_step ? clr_q : wr_addr_q;
  assign a_wdata = cmd.clear_step ? 32'd0 : sum_sat;

  // Accumulator memory
  always_ff @(posedge clk) begin
    if (a_we) amem[a_waddr] <= a_wdata;
    a_rdata <= amem[a_raddr];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= cmd.fin_status;
      saturated  <= cmd.fin_sat && sat_q;
      read_value <= cmd.fin_read ? a_rdata : 32'd0;
    end
  end

endmodule

// File: rtl/core/egsa_checker.sv
// ----------------------------------------------------------------------------
// egsa_checker
// Port-level assertions for the edge gradient scatter-add unit.
// ----------------------------------------------------------------------------
module egsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        status,
  input logic        saturated,
  input logic [31:0] read_value
);

  // A transfer in moves the block out of idle at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted item");

  // Every result is produced while an item is in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobed without an item in progress");

  // Each item yields one result, so strobes never come back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A skipped item never reports saturation.
  a_sat_ok: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> !status)
    else $error("saturation flagged on a skipped item");

  // Read data only accompanies a successful read.
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (read_value != 32'd0)) |-> (!status && !saturated))
    else $error("read data on a result that is not a successful read");

endmodule

bind edge_gradient_scatter_add_unit egsa_checker u_egsa_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .saturated  (saturated),
  .read_value (read_value)
);
